// ===== sv/hpv_pkg.sv =====
package hpv_pkg;

	// Operation codes of an input transaction
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_BATTERY = 2'd1;
	localparam logic [1:0] OP_LOAD    = 2'd2;

	// Fault codes
	localparam logic [1:0] FAULT_NONE    = 2'd0;
	localparam logic [1:0] FAULT_SHORT   = 2'd1;
	localparam logic [1:0] FAULT_LOW_BAT = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_TARGET_MV   = 3'd0;
	localparam logic [2:0] REG_DUTY_MAX    = 3'd1;
	localparam logic [2:0] REG_DUTY_MIN    = 3'd2;
	localparam logic [2:0] REG_SQUARE_MODE = 3'd3;
	localparam logic [2:0] REG_SHORT_THR   = 3'd4;
	localparam logic [2:0] REG_LOW_BAT_MV  = 3'd5;
	localparam logic [2:0] REG_BAT_OFFSET  = 3'd6;

	// Datapath widths
	localparam int ADC_W     = 12;
	localparam int MV_W      = 13;
	localparam int VDD_W     = 16;
	localparam int DUTY_W    = 8;
	localparam int OFS_W     = 10;
	localparam int LOW_W     = 5;
	localparam int CV_W      = 18;
	localparam int MUL_W     = 34;
	localparam int MUL_B     = 16;
	localparam int MUL_CNT_W = 5;
	localparam int DIV_W     = 34;
	localparam int DVS_W     = 32;
	localparam int DIV_CNT_W = 6;

	// Supply conversion: millivolts = REF_NUM / battery average
	localparam int               REF_NUM_W = 23;
	localparam logic [22:0]      REF_NUM   = 23'd4915200;
	localparam logic [15:0]      VDD_SAT   = 16'hFFFF;
	localparam logic [LOW_W-1:0] LOW_SAT   = 5'd31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BAT_AVG,
		ST_BAT_DIV,
		ST_BAT_LOW,
		ST_LOAD_AVG,
		ST_LOAD_MV,
		ST_LAW_T2,
		ST_LAW_NUM,
		ST_LAW_DEN,
		ST_LAW_DIV,
		ST_FINISH
	} hpv_state_t;

	typedef struct packed {
		logic                 go;
		logic [MUL_W-1:0]     mcand;
		logic [MUL_B-1:0]     mplier;
		logic [MUL_CNT_W-1:0] steps;
	} mul_req_t;

	typedef struct packed {
		logic                 go;
		logic [DIV_W-1:0]     dvd;
		logic [DVS_W-1:0]     dvs;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

endpackage

// ===== sv/hpv_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
module hpv_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hpv_pkg::mul_req_t           req,
	output logic                        done,
	output logic [hpv_pkg::MUL_W-1:0]   product
);

	logic                            busy_q;
	logic                            done_q;
	logic [hpv_pkg::MUL_CNT_W-1:0]   cnt_q;
	logic [hpv_pkg::MUL_W-1:0]       acc_q;
	logic [hpv_pkg::MUL_W-1:0]       mcand_q;
	logic [hpv_pkg::MUL_B-1:0]       mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == hpv_pkg::MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			acc_q    <= '0;
			mcand_q  <= req.mcand;
			mplier_q <= req.mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[hpv_pkg::MUL_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[hpv_pkg::MUL_B-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== sv/hpv_div.sv =====
// Restoring divider, one quotient bit per cycle. The dividend is left aligned,
// so a short dividend needs only as many steps as it has bits.
module hpv_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hpv_pkg::div_req_t           req,
	output logic                        done,
	output logic [hpv_pkg::DIV_W-1:0]   quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [hpv_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [hpv_pkg::DVS_W-1:0]       rem_q;
	logic [hpv_pkg::DIV_W-1:0]       dvd_q;
	logic [hpv_pkg::DVS_W-1:0]       dvs_q;
	logic [hpv_pkg::DIV_W-1:0]       quo_q;
	logic [hpv_pkg::DVS_W:0]         trial;
	logic                            fits;

	assign trial = {rem_q, dvd_q[hpv_pkg::DIV_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == hpv_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			dvd_q <= req.dvd;
			dvs_q <= req.dvs;
			quo_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top trial bit drops out
			if (fits) begin
				rem_q <= hpv_pkg::DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[hpv_pkg::DVS_W-1:0];
			end
			dvd_q <= {dvd_q[hpv_pkg::DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[hpv_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/heater_pwm_voltage_regulator.sv =====
// Heater PWM voltage regulator. Every input transaction (start, battery
// reference sample, load sample or unused opcode) yields exactly one result
// transaction that shows both duties, the supply millivolts, the fault code
// and the running flag as they stand after that item. Items are handled one
// at a time by a sequencer that drives a bit-serial shift-and-add multiplier
// and a bit-serial restoring divider; these two units set the latency. A
// completed battery average runs an averaging division over the S bits of
// the sample sum (15 for five samples) and, for a nonzero average, a 23 bit
// reference division. Start runs 13, 8 and 16 bit products and a 34 bit
// division in square mode, an 8 bit product and the 34 bit division in linear
// mode, the division only for a nonzero source; a completed load average adds
// the averaging division and a 12 bit scaling product first. in_stall stays
// high while an item is in work, and the finished result waits in the output
// register while out_stall is high, so the next item can already be taken.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while the block is idle.
module heater_pwm_voltage_regulator #(
	parameter int AVG_SAMPLES   = 5,
	parameter int LOW_BAT_LIMIT = 30
) (
	input  logic        clk,
	input  logic        arst_n,

	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic        channel,
	input  logic [11:0] adc_value,
	input  logic [11:0] adc_recheck,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  duty_left,
	output logic [7:0]  duty_right,
	output logic [15:0] supply_mv,
	output logic [1:0]  fault,
	output logic        running,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	// Sample sum and averager counter widths follow the averaging depth
	localparam int SUM_W = $clog2(4095 * AVG_SAMPLES + 1);
	localparam int CNT_W = $clog2(AVG_SAMPLES + 1);

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [hpv_pkg::MV_W-1:0]   target_mv_q;
	logic [hpv_pkg::DUTY_W-1:0] duty_max_q;
	logic [hpv_pkg::DUTY_W-1:0] duty_min_q;
	logic                       square_mode_q;
	logic [hpv_pkg::ADC_W-1:0]  short_thr_q;
	logic [hpv_pkg::MV_W-1:0]   low_bat_mv_q;
	logic [hpv_pkg::OFS_W-1:0]  bat_offset_q;

	// ---------------------------------------------------------------------
	// Regulator state
	// ---------------------------------------------------------------------
	hpv_pkg::hpv_state_t        state_q, state_d;
	logic                       kick_q;
	logic [hpv_pkg::VDD_W-1:0]  vdd_q;
	logic [SUM_W-1:0]           bat_sum_q;
	logic [CNT_W-1:0]           bat_cnt_q;
	logic [hpv_pkg::LOW_W-1:0]  low_cnt_q;
	logic [SUM_W-1:0]           load_sum_q [2];
	logic [CNT_W-1:0]           load_cnt_q [2];
	logic [hpv_pkg::DUTY_W-1:0] duty_q [2];
	logic                       heating_q;
	logic [1:0]                 fault_q;

	// Work registers of the item in progress
	logic [SUM_W-1:0]           wk_q;
	logic [hpv_pkg::ADC_W-1:0]  avg_q;
	logic [hpv_pkg::VDD_W-1:0]  v_q;
	logic [hpv_pkg::MUL_W-1:0]  num_q;
	logic [hpv_pkg::DVS_W-1:0]  den_q;
	logic                       ch_q;
	logic                       law_both_q;

	// Result register
	logic                       out_valid_q;
	logic [7:0]                 out_duty_l_q;
	logic [7:0]                 out_duty_r_q;
	logic [15:0]                out_supply_q;
	logic [1:0]                 out_fault_q;
	logic                       out_running_q;

	// Arithmetic units
	hpv_pkg::mul_req_t          mul_req;
	hpv_pkg::div_req_t          div_req;
	logic                       mul_done;
	logic                       div_done;
	logic [hpv_pkg::MUL_W-1:0]  mul_prod;
	logic [hpv_pkg::DIV_W-1:0]  div_quo;

	hpv_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (mul_prod)
	);

	hpv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------------------------------------------------------------
	// Combinational helpers
	// ---------------------------------------------------------------------
	logic                       accept;
	logic                       slot_free;
	logic [SUM_W-1:0]           bat_sum_next;
	logic [CNT_W-1:0]           bat_cnt_next;
	logic                       bat_full;
	logic                       adc_low;
	logic                       recheck_low;
	logic                       load_short;
	logic [hpv_pkg::ADC_W-1:0]  load_sample;
	logic [SUM_W-1:0]           load_sum_next;
	logic [CNT_W-1:0]           load_cnt_next;
	logic                       load_full;
	logic signed [hpv_pkg::CV_W-1:0] cv;
	logic [hpv_pkg::VDD_W-1:0]  cv_sat;
	logic                       bat_low;
	logic [hpv_pkg::LOW_W-1:0]  low_next;
	logic                       low_trip;
	logic [hpv_pkg::DUTY_W-1:0] law_duty;
	logic [hpv_pkg::VDD_W-1:0]  vdd_conv;
	hpv_pkg::hpv_state_t        law_entry;
	logic                       do_stop;
	logic [1:0]                 stop_code;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// Battery averager
	assign bat_sum_next = bat_sum_q + SUM_W'(adc_value);
	assign bat_cnt_next = bat_cnt_q + 1'b1;
	assign bat_full     = (bat_cnt_next == CNT_W'(AVG_SAMPLES));

	// Load short check: a low recheck confirms, otherwise average the recheck
	assign adc_low       = (adc_value < short_thr_q);
	assign recheck_low   = (adc_recheck < short_thr_q);
	assign load_short    = adc_low && recheck_low;
	assign load_sample   = adc_low ? adc_recheck : adc_value;
	assign load_sum_next = load_sum_q[channel] + SUM_W'(load_sample);
	assign load_cnt_next = load_cnt_q[channel] + 1'b1;
	assign load_full     = (load_cnt_next == CNT_W'(AVG_SAMPLES));

	// Supply with offset, signed, and its clamp to 0..65535
	assign cv = $signed({2'b00, vdd_q})
		+ $signed({{(hpv_pkg::CV_W - hpv_pkg::OFS_W){bat_offset_q[hpv_pkg::OFS_W-1]}},
			bat_offset_q});

	always_comb begin
		if (cv[hpv_pkg::CV_W-1]) begin
			cv_sat = '0;
		end else if (cv[hpv_pkg::CV_W-2]) begin
			cv_sat = hpv_pkg::VDD_SAT;
		end else begin
			cv_sat = cv[hpv_pkg::VDD_W-1:0];
		end
	end

	// Low battery counting, saturating at its top
	assign bat_low  = (cv < $signed({5'b00000, low_bat_mv_q}));
	assign low_next = (low_cnt_q < hpv_pkg::LOW_SAT) ? low_cnt_q + 1'b1 : low_cnt_q;
	assign low_trip = heating_q && bat_low && (low_next > hpv_pkg::LOW_W'(LOW_BAT_LIMIT));

	// Clamp the quotient: upper limit first, then lower
	always_comb begin
		if (div_quo > hpv_pkg::DIV_W'(duty_max_q)) begin
			law_duty = duty_max_q;
		end else if (div_quo < hpv_pkg::DIV_W'(duty_min_q)) begin
			law_duty = duty_min_q;
		end else begin
			law_duty = div_quo[hpv_pkg::DUTY_W-1:0];
		end
	end

	// Supply millivolts from the division, saturating
	assign vdd_conv = (div_quo > hpv_pkg::DIV_W'(hpv_pkg::VDD_SAT)) ?
		hpv_pkg::VDD_SAT : div_quo[hpv_pkg::VDD_W-1:0];

	// Square mode squares target and source first; linear goes straight to scaling
	assign law_entry = square_mode_q ? hpv_pkg::ST_LAW_T2 : hpv_pkg::ST_LAW_NUM;

	// ---------------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hpv_pkg::ST_IDLE: begin
				if (accept) begin
					case (opcode)
						hpv_pkg::OP_START: begin
							state_d = law_entry;
						end
						hpv_pkg::OP_BATTERY: begin
							state_d = bat_full ? hpv_pkg::ST_BAT_AVG : hpv_pkg::ST_FINISH;
						end
						hpv_pkg::OP_LOAD: begin
							if (heating_q && !load_short && load_full) begin
								state_d = hpv_pkg::ST_LOAD_AVG;
							end else begin
								state_d = hpv_pkg::ST_FINISH;
							end
						end
						default: begin
							state_d = hpv_pkg::ST_FINISH;
						end
					endcase
				end
			end
			hpv_pkg::ST_BAT_AVG: begin
				if (div_done) begin
					state_d = (div_quo == '0) ? hpv_pkg::ST_BAT_LOW : hpv_pkg::ST_BAT_DIV;
				end
			end
			hpv_pkg::ST_BAT_DIV: begin
				if (div_done) begin
					state_d = hpv_pkg::ST_BAT_LOW;
				end
			end
			hpv_pkg::ST_BAT_LOW: begin
				state_d = hpv_pkg::ST_FINISH;
			end
			hpv_pkg::ST_LOAD_AVG: begin
				if (div_done) begin
					state_d = hpv_pkg::ST_LOAD_MV;
				end
			end
			hpv_pkg::ST_LOAD_MV: begin
				if (mul_done) begin
					state_d = law_entry;
				end
			end
			hpv_pkg::ST_LAW_T2: begin
				if (mul_done) begin
					state_d = hpv_pkg::ST_LAW_NUM;
				end
			end
			hpv_pkg::ST_LAW_NUM: begin
				if (mul_done) begin
					state_d = square_mode_q ? hpv_pkg::ST_LAW_DEN : hpv_pkg::ST_LAW_DIV;
				end
			end
			hpv_pkg::ST_LAW_DEN: begin
				if (mul_done) begin
					state_d = hpv_pkg::ST_LAW_DIV;
				end
			end
			hpv_pkg::ST_LAW_DIV: begin
				// a zero source voltage saturates without a division
				if ((kick_q && den_q == '0) || div_done) begin
					state_d = hpv_pkg::ST_FINISH;
				end
			end
			hpv_pkg::ST_FINISH: begin
				if (slot_free) begin
					state_d = hpv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hpv_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequencer: outputs (unit launches, stop requests)
	// ---------------------------------------------------------------------
	always_comb begin
		mul_req   = '0;
		div_req   = '0;
		do_stop   = 1'b0;
		stop_code = hpv_pkg::FAULT_NONE;
		unique case (state_q)
			hpv_pkg::ST_IDLE: begin
				if (accept && opcode == hpv_pkg::OP_START) begin
					do_stop   = 1'b1;
					stop_code = hpv_pkg::FAULT_NONE;
				end else if (accept && opcode == hpv_pkg::OP_LOAD && heating_q && load_short) begin
					do_stop   = 1'b1;
					stop_code = hpv_pkg::FAULT_SHORT;
				end
			end
			hpv_pkg::ST_BAT_AVG, hpv_pkg::ST_LOAD_AVG: begin
				div_req.go    = kick_q;
				div_req.dvd   = {wk_q, {(hpv_pkg::DIV_W - SUM_W){1'b0}}};
				div_req.dvs   = hpv_pkg::DVS_W'(AVG_SAMPLES);
				div_req.steps = hpv_pkg::DIV_CNT_W'(SUM_W);
			end
			hpv_pkg::ST_BAT_DIV: begin
				div_req.go    = kick_q;
				div_req.dvd   = {hpv_pkg::REF_NUM, {(hpv_pkg::DIV_W - hpv_pkg::REF_NUM_W){1'b0}}};
				div_req.dvs   = hpv_pkg::DVS_W'(avg_q);
				div_req.steps = hpv_pkg::DIV_CNT_W'(hpv_pkg::REF_NUM_W);
			end
			hpv_pkg::ST_BAT_LOW: begin
				if (low_trip) begin
					do_stop   = 1'b1;
					stop_code = hpv_pkg::FAULT_LOW_BAT;
				end
			end
			hpv_pkg::ST_LOAD_MV: begin
				mul_req.go     = kick_q;
				mul_req.mcand  = hpv_pkg::MUL_W'(vdd_q);
				mul_req.mplier = hpv_pkg::MUL_B'(avg_q);
				mul_req.steps  = hpv_pkg::MUL_CNT_W'(hpv_pkg::ADC_W);
			end
			hpv_pkg::ST_LAW_T2: begin
				mul_req.go     = kick_q;
				mul_req.mcand  = hpv_pkg::MUL_W'(target_mv_q);
				mul_req.mplier = hpv_pkg::MUL_B'(target_mv_q);
				mul_req.steps  = hpv_pkg::MUL_CNT_W'(hpv_pkg::MV_W);
			end
			hpv_pkg::ST_LAW_NUM: begin
				mul_req.go     = kick_q;
				mul_req.mcand  = num_q;
				mul_req.mplier = hpv_pkg::MUL_B'(duty_max_q);
				mul_req.steps  = hpv_pkg::MUL_CNT_W'(hpv_pkg::DUTY_W);
			end
			hpv_pkg::ST_LAW_DEN: begin
				mul_req.go     = kick_q;
				mul_req.mcand  = hpv_pkg::MUL_W'(v_q);
				mul_req.mplier = v_q;
				mul_req.steps  = hpv_pkg::MUL_CNT_W'(hpv_pkg::VDD_W);
			end
			hpv_pkg::ST_LAW_DIV: begin
				div_req.go    = kick_q && (den_q != '0);
				div_req.dvd   = num_q;
				div_req.dvs   = den_q;
				div_req.steps = hpv_pkg::DIV_CNT_W'(hpv_pkg::DIV_W);
			end
			hpv_pkg::ST_FINISH: begin
				do_stop = 1'b0;
			end
			default: begin
				do_stop = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_mv_q   <= 13'd3300;
			duty_max_q    <= 8'd100;
			duty_min_q    <= 8'd0;
			square_mode_q <= 1'b1;
			short_thr_q   <= 12'd100;
			low_bat_mv_q  <= 13'd3300;
			bat_offset_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hpv_pkg::REG_TARGET_MV:   target_mv_q   <= cfg_data;
				hpv_pkg::REG_DUTY_MAX:    duty_max_q    <= cfg_data[7:0];
				hpv_pkg::REG_DUTY_MIN:    duty_min_q    <= cfg_data[7:0];
				hpv_pkg::REG_SQUARE_MODE: square_mode_q <= cfg_data[0];
				hpv_pkg::REG_SHORT_THR:   short_thr_q   <= cfg_data[11:0];
				hpv_pkg::REG_LOW_BAT_MV:  low_bat_mv_q  <= cfg_data;
				hpv_pkg::REG_BAT_OFFSET:  bat_offset_q  <= cfg_data[9:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer state and regulator state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= hpv_pkg::ST_IDLE;
			kick_q        <= 1'b0;
			vdd_q         <= '0;
			bat_sum_q     <= '0;
			bat_cnt_q     <= '0;
			low_cnt_q     <= '0;
			load_sum_q[0] <= '0;
			load_sum_q[1] <= '0;
			load_cnt_q[0] <= '0;
			load_cnt_q[1] <= '0;
			duty_q[0]     <= '0;
			duty_q[1]     <= '0;
			heating_q     <= 1'b0;
			fault_q       <= hpv_pkg::FAULT_NONE;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// a fresh state launches its unit job in its first cycle
			kick_q  <= (state_d != state_q);

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				hpv_pkg::ST_IDLE: begin
					if (accept && opcode == hpv_pkg::OP_BATTERY) begin
						if (bat_full) begin
							bat_sum_q <= '0;
							bat_cnt_q <= '0;
						end else begin
							bat_sum_q <= bat_sum_next;
							bat_cnt_q <= bat_cnt_next;
						end
					end else if (accept && opcode == hpv_pkg::OP_LOAD && heating_q
						&& !load_short) begin
						if (load_full) begin
							load_sum_q[channel] <= '0;
							load_cnt_q[channel] <= '0;
						end else begin
							load_sum_q[channel] <= load_sum_next;
							load_cnt_q[channel] <= load_cnt_next;
						end
					end
				end
				hpv_pkg::ST_BAT_AVG: begin
					if (div_done && div_quo == '0) begin
						vdd_q <= hpv_pkg::VDD_SAT;
					end
				end
				hpv_pkg::ST_BAT_DIV: begin
					if (div_done) begin
						vdd_q <= vdd_conv;
					end
				end
				hpv_pkg::ST_BAT_LOW: begin
					// not heating or supply at or above the low limit: clear the count
					if (!heating_q || !bat_low) begin
						low_cnt_q <= '0;
					end else begin
						low_cnt_q <= low_next;
					end
				end
				hpv_pkg::ST_LAW_DIV: begin
					if (kick_q && den_q == '0) begin
						if (law_both_q) begin
							duty_q[0] <= duty_max_q;
							duty_q[1] <= duty_max_q;
						end else begin
							duty_q[ch_q] <= duty_max_q;
						end
					end else if (div_done) begin
						if (law_both_q) begin
							duty_q[0] <= law_duty;
							duty_q[1] <= law_duty;
						end else begin
							duty_q[ch_q] <= law_duty;
						end
					end
				end
				hpv_pkg::ST_FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					// arithmetic states keep the regulator state
				end
			endcase

			// fault or start: drop output, clear averagers and low count
			if (do_stop) begin
				heating_q     <= 1'b0;
				fault_q       <= stop_code;
				duty_q[0]     <= '0;
				duty_q[1]     <= '0;
				bat_sum_q     <= '0;
				bat_cnt_q     <= '0;
				low_cnt_q     <= '0;
				load_sum_q[0] <= '0;
				load_sum_q[1] <= '0;
				load_cnt_q[0] <= '0;
				load_cnt_q[1] <= '0;
			end
			if (accept && opcode == hpv_pkg::OP_START) begin
				heating_q <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Work registers and result register (no reset)
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			hpv_pkg::ST_IDLE: begin
				if (accept) begin
					ch_q       <= channel;
					law_both_q <= (opcode == hpv_pkg::OP_START);
					// linear mode scales the bare target
					num_q      <= hpv_pkg::MUL_W'(target_mv_q);
					v_q        <= cv_sat;
					wk_q       <= (opcode == hpv_pkg::OP_BATTERY) ? bat_sum_next : load_sum_next;
				end
			end
			hpv_pkg::ST_BAT_AVG, hpv_pkg::ST_LOAD_AVG: begin
				if (div_done) begin
					avg_q <= div_quo[hpv_pkg::ADC_W-1:0];
				end
			end
			hpv_pkg::ST_LOAD_MV: begin
				// millivolts = average * supply / 4096
				if (mul_done) begin
					v_q <= mul_prod[hpv_pkg::VDD_W+hpv_pkg::ADC_W-1:hpv_pkg::ADC_W];
				end
			end
			hpv_pkg::ST_LAW_T2: begin
				if (mul_done) begin
					num_q <= mul_prod;
				end
			end
			hpv_pkg::ST_LAW_NUM: begin
				if (mul_done) begin
					num_q <= mul_prod;
					den_q <= hpv_pkg::DVS_W'(v_q);
				end
			end
			hpv_pkg::ST_LAW_DEN: begin
				if (mul_done) begin
					den_q <= mul_prod[hpv_pkg::DVS_W-1:0];
				end
			end
			hpv_pkg::ST_FINISH: begin
				if (slot_free) begin
					out_duty_l_q  <= duty_q[0];
					out_duty_r_q  <= duty_q[1];
					out_supply_q  <= vdd_q;
					out_fault_q   <= fault_q;
					out_running_q <= heating_q;
				end
			end
			default: begin
				// hold
			end
		endcase
	end

	assign in_stall   = (state_q != hpv_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign duty_left  = out_duty_l_q;
	assign duty_right = out_duty_r_q;
	assign supply_mv  = out_supply_q;
	assign fault      = out_fault_q;
	assign running    = out_running_q;

endmodule

// ===== sv/hpv_checker.sv =====
module hpv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  opcode,
	input logic        channel,
	input logic [11:0] adc_value,
	input logic [11:0] adc_recheck,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  duty_left,
	input logic [7:0]  duty_right,
	input logic [15:0] supply_mv,
	input logic [1:0]  fault,
	input logic        running,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [12:0] cfg_data
);

	// a waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty_left)
			&& $stable(duty_right) && $stable(supply_mv) && $stable(fault)
			&& $stable(running))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in work");

	// stopped output shows zero duty
	a_idle_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running |-> duty_left == 8'd0 && duty_right == 8'd0)
		else $error("duty shown while output is stopped");

	// a fault always stops the output
	a_fault_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault != 2'd0 |-> !running)
		else $error("running with a fault raised");

	// only defined fault codes reach the port
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fault != 2'd3)
		else $error("undefined fault code");

endmodule

bind heater_pwm_voltage_regulator hpv_checker u_hpv_checker (.*);

// ===== test/tb_heater_pwm_voltage_regulator.sv =====
module tb_heater_pwm_voltage_regulator;
	timeunit 1ns;
	timeprecision 1ps;

	import hpv_pkg::*;

	localparam int AVG_SAMPLES    = 5;
	localparam int LOW_BAT_LIMIT  = 30;
	localparam int LOW_CNT_SAT    = 31;
	localparam int REF_MV_NUM     = 4915200;
	localparam int ADC_SPAN       = 4096;
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
	localparam int SETTLE_CYCLES  = 150;   // above the slowest item of the block
	localparam int PHASE_ITEMS    = 150;
	localparam int MAX_REPORTS    = 10;

	// One result transaction, field for field as the block presents it
	typedef struct packed {
		logic [7:0]  duty_left;
		logic [7:0]  duty_right;
		logic [15:0] supply_mv;
		logic [1:0]  fault;
		logic        running;
	} heater_status_t;

	// Scoreboard: keeps its own copy of the regulator state and settings,
	// works out the status that each accepted item leaves behind and queues
	// it until the block delivers the matching result.
	class duty_scoreboard;
		logic [12:0]       target_mv;
		logic [7:0]        duty_max;
		logic [7:0]        duty_min;
		logic              square_mode;
		logic [11:0]       short_thr;
		logic [12:0]       low_bat_mv;
		logic signed [9:0] bat_offset;

		logic [15:0] vdd_mv;
		logic [14:0] bat_sum;
		int unsigned bat_cnt;
		int unsigned low_cnt;
		logic [14:0] load_sum [2];
		int unsigned load_cnt [2];
		logic [7:0]  duty [2];
		logic        heating;
		logic [1:0]  fault_code;

		heater_status_t status_q [$];
		int unsigned    errors;

		function new();
			target_mv   = 13'd3300;
			duty_max    = 8'd100;
			duty_min    = 8'd0;
			square_mode = 1'b1;
			short_thr   = 12'd100;
			low_bat_mv  = 13'd3300;
			bat_offset  = '0;
			vdd_mv      = '0;
			errors      = 0;
			shut_down(FAULT_NONE);
		endfunction

		function void shut_down(logic [1:0] code);
			heating     = 1'b0;
			fault_code  = code;
			duty[0]     = '0;
			duty[1]     = '0;
			load_sum[0] = '0;
			load_sum[1] = '0;
			load_cnt[0] = 0;
			load_cnt[1] = 0;
			bat_sum     = '0;
			bat_cnt     = 0;
			low_cnt     = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [12:0] data);
			case (idx)
				REG_TARGET_MV:   target_mv   = data;
				REG_DUTY_MAX:    duty_max    = data[7:0];
				REG_DUTY_MIN:    duty_min    = data[7:0];
				REG_SQUARE_MODE: square_mode = data[0];
				REG_SHORT_THR:   short_thr   = data[11:0];
				REG_LOW_BAT_MV:  low_bat_mv  = data;
				REG_BAT_OFFSET:  bat_offset  = data[9:0];
				default: ;
			endcase
		endfunction

		// Duty law against the target, quotient clamped to max first, then min
		function logic [7:0] law_duty(longint unsigned vsrc);
			longint unsigned num, den, q;
			num = target_mv;
			den = vsrc;
			if (square_mode) begin
				num = num * num;
				den = den * den;
			end
			num = num * duty_max;
			if (den == 0)
				return duty_max;
			q = num / den;
			if (q > duty_max)
				return duty_max;
			if (q < duty_min)
				return duty_min;
			return q[7:0];
		endfunction

		function longint unsigned corrected_supply();
			int v;
			v = int'(vdd_mv) + int'(bat_offset);
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			return v;
		endfunction

		function void battery_sample(logic [11:0] adc);
			int unsigned avg, mv;
			bat_sum += adc;
			bat_cnt++;
			if (bat_cnt < AVG_SAMPLES)
				return;
			avg     = int'(bat_sum) / AVG_SAMPLES;
			bat_sum = '0;
			bat_cnt = 0;
			if (avg == 0)
				mv = 65535;
			else begin
				mv = REF_MV_NUM / avg;
				if (mv > 65535)
					mv = 65535;
			end
			vdd_mv = mv[15:0];
			if (!heating) begin
				low_cnt = 0;
				return;
			end
			if (int'(vdd_mv) + int'(bat_offset) < int'(low_bat_mv)) begin
				if (low_cnt < LOW_CNT_SAT)
					low_cnt++;
				if (low_cnt > LOW_BAT_LIMIT)
					shut_down(FAULT_LOW_BAT);
			end else
				low_cnt = 0;
		endfunction

		function void load_sample(logic ch, logic [11:0] adc, logic [11:0] rechk);
			logic [11:0]     sample;
			longint unsigned avg, mv;
			if (!heating)
				return;
			sample = adc;
			if (adc < short_thr) begin
				if (rechk < short_thr) begin
					shut_down(FAULT_SHORT);
					return;
				end
				sample = rechk;
			end
			load_sum[ch] += sample;
			load_cnt[ch]++;
			if (load_cnt[ch] < AVG_SAMPLES)
				return;
			avg          = load_sum[ch];
			avg          = avg / AVG_SAMPLES;
			load_sum[ch] = '0;
			load_cnt[ch] = 0;
			mv           = (avg * vdd_mv) / ADC_SPAN;
			duty[ch]     = law_duty(mv);
		endfunction

		// True when the item changes anything in the block
		function bit is_active(logic [1:0] op);
			return op == OP_START || op == OP_BATTERY || (op == OP_LOAD && heating);
		endfunction

		function void note_item(logic [1:0] op, logic ch, logic [11:0] adc, logic [11:0] rechk);
			case (op)
				OP_START: begin
					shut_down(FAULT_NONE);
					duty[0] = law_duty(corrected_supply());
					duty[1] = duty[0];
					heating = 1'b1;
				end
				OP_BATTERY: battery_sample(adc);
				OP_LOAD:    load_sample(ch, adc, rechk);
				default: ;
			endcase
			status_q.push_back(heater_status_t'{duty[0], duty[1], vdd_mv, fault_code, heating});
		endfunction

		function void check_result(heater_status_t got);
			heater_status_t want;
			if (status_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result duty %0d/%0d supply %0d fault %0d run %0d",
						$realtime, got.duty_left, got.duty_right, got.supply_mv,
						got.fault, got.running);
				return;
			end
			want = status_q.pop_front();
			if (got.duty_left !== want.duty_left || got.duty_right !== want.duty_right ||
				got.supply_mv !== want.supply_mv || got.fault !== want.fault ||
				got.running !== want.running) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"%0t: mismatch, expected duty %0d/%0d supply %0d fault %0d run %0d,",
						" got duty %0d/%0d supply %0d fault %0d run %0d"}, $realtime,
						want.duty_left, want.duty_right, want.supply_mv, want.fault,
						want.running, got.duty_left, got.duty_right, got.supply_mv,
						got.fault, got.running);
			end
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	// Block ports; every input starts at a known value
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode      = '0;
	logic        channel     = 1'b0;
	logic [11:0] adc_value   = '0;
	logic [11:0] adc_recheck = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [7:0]  duty_left;
	logic [7:0]  duty_right;
	logic [15:0] supply_mv;
	logic [1:0]  fault;
	logic        running;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index   = '0;
	logic [12:0] cfg_data    = '0;

	duty_scoreboard sb;
	bit             no_idle     = 1'b0;  // both sides run flat out while set
	bit             hold_go     = 1'b0;  // asks the receiver for one long hold-off
	int             hold_left   = 0;
	int             quiet_cycles = 0;
	int             items_done  = 0;     // items that actually changed the block

	heater_pwm_voltage_regulator #(
		.AVG_SAMPLES   (AVG_SAMPLES),
		.LOW_BAT_LIMIT (LOW_BAT_LIMIT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.channel     (channel),
		.adc_value   (adc_value),
		.adc_recheck (adc_recheck),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.duty_left   (duty_left),
		.duty_right  (duty_right),
		.supply_mv   (supply_mv),
		.fault       (fault),
		.running     (running),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: end the run once nothing has moved for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: check each accepted result transaction, then decide the
	// stall for the next cycle. A hold-off request keeps the stall high for a
	// long stretch so that the block fills up behind it.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(heater_status_t'{duty_left, duty_right, supply_mv, fault, running});
		if (hold_go) begin
			hold_go   = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= !no_idle && ($urandom_range(99) < 36);
	end

	// Offer one input transaction after a random gap, hold it until taken.
	// The valid is left high on return so back-to-back items never drop it.
	task automatic send_item(logic [1:0] op, logic ch, logic [11:0] adc, logic [11:0] rechk);
		while (!no_idle && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		channel     <= ch;
		adc_value   <= adc;
		adc_recheck <= rechk;
		do
			@(posedge clk);
		while (in_stall);
		if (sb.is_active(op))
			items_done++;
		sb.note_item(op, ch, adc, rechk);
	endtask

	// Drop the valid and wait until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [12:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// Write the whole register set; only ever called with the block idle
	task automatic apply_config(int target, int dmax, int dmin, int sq, int thr, int low, int ofs);
		logic [9:0] ofs_bits;
		ofs_bits = ofs[9:0];
		drain();
		write_reg(REG_TARGET_MV, target[12:0]);
		write_reg(REG_DUTY_MAX, {5'd0, dmax[7:0]});
		write_reg(REG_DUTY_MIN, {5'd0, dmin[7:0]});
		write_reg(REG_SQUARE_MODE, {12'd0, sq[0]});
		write_reg(REG_SHORT_THR, {1'b0, thr[11:0]});
		write_reg(REG_LOW_BAT_MV, low[12:0]);
		write_reg(REG_BAT_OFFSET, {3'd0, ofs_bits});
		cfg_valid <= 1'b0;
	endtask

	task automatic bat_item(int lo, int hi);
		send_item(OP_BATTERY, $urandom_range(1), $urandom_range(hi, lo), $urandom());
	endtask

	// Load sample; a quiet one never trips the short check
	task automatic load_item(logic ch, bit quiet);
		int          s;
		int          thr;
		logic [11:0] a, r;
		thr = sb.short_thr;
		s   = $urandom_range(99);
		r   = $urandom();
		if (!quiet && thr != 0 && s < 3) begin
			a = $urandom_range(thr - 1, 0);
			r = $urandom_range(thr - 1, 0);
		end else if (thr != 0 && s < 13) begin
			a = $urandom_range(thr - 1, 0);
			r = $urandom_range(4095, thr);
		end else if (!quiet && s < 20)
			a = ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
		else
			a = $urandom_range(4095, thr);
		send_item(OP_LOAD, ch, a, r);
	endtask

	// Start, then a stretch of battery and load samples around one supply level
	task automatic heating_session();
		int base, spread, len;
		base   = $urandom_range(2200, 900);
		spread = $urandom_range(300, 0);
		if ($urandom_range(1) != 0)
			repeat (AVG_SAMPLES) bat_item(base, base + spread);
		send_item(OP_START, $urandom_range(1), $urandom(), $urandom());
		len = $urandom_range(60, 20);
		repeat (len) begin
			if ($urandom_range(99) < 40)
				bat_item(base, base + spread);
			else
				load_item($urandom_range(1), 1'b0);
		end
	endtask

	// Start, then keep the corrected supply under the low limit, as far as the ADC range
	// allows, long enough for the low battery fault to fire
	task automatic low_battery_run();
		int lim, lo;
		lim = int'(sb.low_bat_mv) - int'(sb.bat_offset);
		lo  = (lim > 1) ? REF_MV_NUM / (lim - 1) + 1 : 4095;
		if (lo > 4095)
			lo = 4095;
		send_item(OP_START, $urandom_range(1), $urandom(), $urandom());
		repeat (200) begin
			if ($urandom_range(99) < 85)
				bat_item(lo, 4095);
			else
				load_item($urandom_range(1), 1'b1);
		end
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(8, 1))
			send_item($urandom_range(3), $urandom_range(1), $urandom(), $urandom());
	endtask

	task automatic random_phase(int n);
		int stop_at, pick;
		stop_at = items_done + n;
		while (items_done < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55)
				heating_session();
			else if (pick < 70)
				low_battery_run();
			else if (pick < 80)
				repeat (AVG_SAMPLES) bat_item(0, 80);  // tiny averages saturate the supply
			else
				noise_burst();
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings
		send_item(2'd3, 1'b1, 12'hFFF, 12'hFFF);            // unused opcode, ignored
		send_item(OP_LOAD, 1'b1, 12'hFFF, 12'h000);         // load while idle, ignored
		send_item(OP_START, 1'b0, 12'h000, 12'h000);        // no supply yet: zero divisor
		repeat (AVG_SAMPLES)
			send_item(OP_BATTERY, 1'b0, 12'h000, 12'h000);  // zero battery average saturates
		send_item(OP_START, 1'b1, 12'h000, 12'hFFF);        // seed from saturated supply
		repeat (AVG_SAMPLES)
			send_item(OP_BATTERY, 1'b1, 12'hFFF, 12'h000);  // full scale gives a low supply
		send_item(OP_LOAD, 1'b0, 12'd50, 12'hFFF);          // first read low, recheck averaged
		repeat (AVG_SAMPLES - 1)
			send_item(OP_LOAD, 1'b0, 12'hFFF, 12'h000);
		send_item(OP_LOAD, 1'b1, 12'h000, 12'd99);          // both reads low: short
		send_item(OP_START, 1'b0, 12'h000, 12'h000);        // restart clears the fault

		// Upper extremes
		apply_config(5000, 255, 0, 1, 4095, 5000, 511);
		random_phase(PHASE_ITEMS);

		// Lower extremes, linear law, min clamp above max
		apply_config(0, 1, 255, 0, 0, 0, -512);
		send_item(OP_START, 1'b0, 12'h000, 12'h000);
		repeat (AVG_SAMPLES)
			send_item(OP_LOAD, 1'b0, 12'h000, 12'h000);     // zero load voltage
		random_phase(PHASE_ITEMS);

		apply_config($urandom_range(5000, 0), $urandom_range(255, 1), $urandom_range(60, 0), 1,
			$urandom_range(4095, 0), $urandom_range(5000, 0), $urandom_range(1023, 0));
		random_phase(PHASE_ITEMS);

		// Reset values, no idling, one long receiver hold-off, then a full pause
		apply_config(3300, 100, 0, 1, 100, 3300, 0);
		no_idle = 1'b1;
		hold_go = 1'b1;
		random_phase(PHASE_ITEMS / 2);
		no_idle = 1'b0;
		drain();
		random_phase(PHASE_ITEMS / 2);

		apply_config($urandom_range(5000, 0), $urandom_range(255, 1), $urandom_range(255, 0),
			$urandom_range(1, 0), $urandom_range(4095, 0), $urandom_range(5000, 0),
			$urandom_range(1023, 0));
		random_phase(PHASE_ITEMS);

		apply_config($urandom_range(5000, 1000), $urandom_range(255, 1), $urandom_range(20, 0), 0,
			$urandom_range(400, 1), $urandom_range(4500, 2500), $urandom_range(1023, 0));
		random_phase(PHASE_ITEMS);

		// Wait out the last results, then allow a stray one to show up
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
